>>> rtl/rtc3w_pkg.sv
// package for the three-wire rtc serial master
// holds the mode type, command codes and fixed widths; no dependencies
`default_nettype none

package rtc3w_pkg;

	// transaction mode
	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_READ  = 2'd2,
		MODE_INIT  = 2'd3
	} mode_t;

	// item command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_INIT  = 2'd3;

	// configuration register indexes
	localparam logic REG_INIT_TIME = 1'b0;

	localparam int unsigned INIT_TIME_W = 56;
	localparam logic [INIT_TIME_W-1:0] INIT_TIME_RESET = 56'h13021008123000;

	// init sequence steps
	localparam logic [3:0] STEP_READ_HALT  = 4'd0;
	localparam logic [3:0] STEP_WRITE_WP   = 4'd1;
	localparam logic [3:0] STEP_LAST       = 4'd8;

	// fixed device registers used during init
	localparam logic [5:0] DEV_REG_SECONDS = 6'd0;
	localparam logic [5:0] DEV_REG_WP      = 6'd7;
	localparam logic [2:0] LAST_TIME_IDX   = 3'd6;

	// clock halt flag in the seconds register
	localparam int unsigned HALT_BIT = 7;

endpackage

`default_nettype wire

>>> rtl/rtc_three_wire_serial_master_unit.sv
// top level of the three-wire rtc serial master
// depends on rtc3w_pkg for mode type and command codes
`default_nettype none

// Pin-level master for a three-wire real-time-clock bus. Each accepted item
// (a tick or a start command) moves the bus by one half bit and yields one
// result item with the pin levels and status after that item. One item is
// accepted every cycle unless a result waits untaken; each result is held in
// the output register from its transfer until taken, and the next item can
// enter in the same cycle it leaves. The init_time register sits on a 64-bit
// APB port at byte address 0; the user must write it only while idle (the block does not enforce it).
module rtc_three_wire_serial_master_unit
	import rtc3w_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [5:0]  reg_addr,
	input  wire logic [7:0]  write_data,
	input  wire logic        io_in,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             sclk,
	output logic             io_out,
	output logic             io_drive,
	output logic             enable,
	output logic             busy_res,
	output logic             done_res,
	output logic [7:0]       read_data,
	output logic             clock_was_halted,
	output logic             rejected,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	logic [INIT_TIME_W-1:0] init_time_q;

	mode_t       mode_q, mode_d;
	logic [3:0]  init_step_q, init_step_d;
	logic [4:0]  bit_count_q, bit_count_d;
	logic        half_q, half_d;
	logic [15:0] shift_out_q, shift_out_d;
	logic [7:0]  shift_in_q, shift_in_d;
	logic [7:0]  last_read_q, last_read_d;
	logic        halted_q, halted_d;
	logic        done_d, rej_d;

	logic        out_valid_q;
	logic        sclk_q, io_out_q, io_drive_q, enable_q, busy_q, done_q, rej_q;
	logic        sclk_d, io_out_d, io_drive_d, enable_d;

	logic        accept;
	logic        reading_q, reading_d;

	// transaction load request
	logic        ld_en, ld_read;
	logic [5:0]  ld_reg;
	logic [7:0]  ld_data;
	logic        init_ld;
	logic [3:0]  init_sel;
	logic [2:0]  time_idx;
	logic [3:0]  time_off;
	logic [INIT_TIME_W-1:0] time_shifted;
	logic [4:0]  bc_next;

	assign pready   = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// register read back
	always_comb begin
		prdata = '0;
		if (paddr[3] == REG_INIT_TIME)
			prdata = {{(64-INIT_TIME_W){1'b0}}, init_time_q};
	end

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			init_time_q <= INIT_TIME_RESET;
		else if (psel && penable && pwrite && paddr[3] == REG_INIT_TIME)
			init_time_q <= pwdata[INIT_TIME_W-1:0];
	end

	assign reading_q = (mode_q == MODE_READ) ||
		(mode_q == MODE_INIT && init_step_q == STEP_READ_HALT);

	// time byte select for init writes
	assign time_off     = init_sel - 4'd2;
	assign time_idx     = (time_off[2:0] > LAST_TIME_IDX) ? LAST_TIME_IDX : time_off[2:0];
	assign time_shifted = init_time_q >> {time_idx, 3'b000};
	assign bc_next      = bit_count_q + 5'd1;

	// next state
	always_comb begin
		mode_d      = mode_q;
		init_step_d = init_step_q;
		bit_count_d = bit_count_q;
		half_d      = half_q;
		shift_out_d = shift_out_q;
		shift_in_d  = shift_in_q;
		last_read_d = last_read_q;
		halted_d    = halted_q;
		done_d      = 1'b0;
		rej_d       = 1'b0;
		ld_en       = 1'b0;
		ld_read     = 1'b0;
		ld_reg      = '0;
		ld_data     = '0;
		init_ld     = 1'b0;
		init_sel    = init_step_q;

		if (cmd != CMD_TICK) begin
			if (mode_q != MODE_IDLE) begin
				rej_d = 1'b1;
			end else begin
				unique case (cmd)
					CMD_WRITE: begin
						mode_d  = MODE_WRITE;
						ld_en   = 1'b1;
						ld_reg  = reg_addr;
						ld_data = write_data;
					end
					CMD_READ: begin
						mode_d  = MODE_READ;
						ld_en   = 1'b1;
						ld_read = 1'b1;
						ld_reg  = reg_addr;
					end
					default: begin
						mode_d      = MODE_INIT;
						init_step_d = STEP_READ_HALT;
						halted_d    = 1'b0;
						init_ld     = 1'b1;
						init_sel    = STEP_READ_HALT;
					end
				endcase
			end
		end else if (mode_q != MODE_IDLE) begin
			if (bit_count_q[4]) begin
				// gap between init transactions
				init_ld = 1'b1;
			end else if (!half_q) begin
				// sample with sclk low, then raise sclk
				if (reading_q && bit_count_q[3])
					shift_in_d[bit_count_q[2:0]] = io_in;
				half_d = 1'b1;
			end else begin
				// lower sclk and advance
				half_d      = 1'b0;
				bit_count_d = bc_next;
				if (bc_next[4]) begin
					if (reading_q)
						last_read_d = shift_in_q;
					if (mode_q != MODE_INIT) begin
						mode_d      = MODE_IDLE;
						init_step_d = '0;
						bit_count_d = '0;
						done_d      = 1'b1;
					end else if (init_step_q == STEP_READ_HALT) begin
						if (last_read_d[HALT_BIT]) begin
							halted_d    = 1'b1;
							init_step_d = STEP_WRITE_WP;
						end else begin
							mode_d      = MODE_IDLE;
							init_step_d = '0;
							bit_count_d = '0;
							done_d      = 1'b1;
						end
					end else if (init_step_q < STEP_LAST) begin
						init_step_d = init_step_q + 4'd1;
					end else begin
						mode_d      = MODE_IDLE;
						init_step_d = '0;
						bit_count_d = '0;
						done_d      = 1'b1;
					end
				end
			end
		end

		// init step transaction select
		if (init_ld) begin
			ld_en = 1'b1;
			priority if (init_sel == STEP_READ_HALT) begin
				ld_read = 1'b1;
				ld_reg  = DEV_REG_SECONDS;
			end else if (init_sel == STEP_WRITE_WP) begin
				ld_reg  = DEV_REG_WP;
			end else begin
				ld_reg  = {3'b000, time_idx};
				ld_data = time_shifted[7:0];
			end
		end

		// load command and data bytes
		if (ld_en) begin
			shift_out_d = {ld_data, 1'b1, ld_reg, ld_read};
			shift_in_d  = '0;
			bit_count_d = '0;
			half_d      = 1'b0;
		end
	end

	assign reading_d = (mode_d == MODE_READ) ||
		(mode_d == MODE_INIT && init_step_d == STEP_READ_HALT);

	// pin levels after the item
	always_comb begin
		sclk_d     = 1'b0;
		enable_d   = 1'b0;
		io_drive_d = 1'b0;
		io_out_d   = 1'b1;
		if (mode_d != MODE_IDLE && !bit_count_d[4]) begin
			sclk_d   = half_d;
			enable_d = 1'b1;
			if (!bit_count_d[3] || !reading_d) begin
				io_drive_d = 1'b1;
				io_out_d   = shift_out_d[bit_count_d[3:0]];
			end
		end
	end

	// state registers, advanced on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			init_step_q <= '0;
			bit_count_q <= '0;
			half_q      <= 1'b0;
			shift_out_q <= '0;
			shift_in_q  <= '0;
			last_read_q <= '0;
			halted_q    <= 1'b0;
		end else if (accept) begin
			mode_q      <= mode_d;
			init_step_q <= init_step_d;
			bit_count_q <= bit_count_d;
			half_q      <= half_d;
			shift_out_q <= shift_out_d;
			shift_in_q  <= shift_in_d;
			last_read_q <= last_read_d;
			halted_q    <= halted_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sclk_q     <= sclk_d;
			io_out_q   <= io_out_d;
			io_drive_q <= io_drive_d;
			enable_q   <= enable_d;
			busy_q     <= (mode_d != MODE_IDLE);
			done_q     <= done_d;
			rej_q      <= rej_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign sclk             = sclk_q;
	assign io_out           = io_out_q;
	assign io_drive         = io_drive_q;
	assign enable           = enable_q;
	assign busy_res         = busy_q;
	assign done_res         = done_q;
	assign read_data        = last_read_q;
	assign clock_was_halted = halted_q;
	assign rejected         = rej_q;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// testbench for the three-wire rtc serial master unit
// checks every result against an in-bench model of the bus or a pinned value; needs rtc3w_pkg and the unit
`timescale 1ns / 1ps

module testbench;
	import rtc3w_pkg::*;

	// one result: pin levels and status after an item
	typedef struct packed {
		logic       sclk;
		logic       io_out;
		logic       io_drive;
		logic       enable;
		logic       busy;
		logic       done;
		logic [7:0] rd;
		logic       halted;
		logic       rejected;
	} pins_t;

	// one row of the directed stimulus, repeated reps times
	typedef struct packed {
		logic [1:0] op;
		logic [5:0] addr;
		logic [7:0] data;
		logic       pin;
		logic [8:0] reps;
		logic       has_want;
		pins_t      want;
	} stim_row_t;

	localparam int unsigned FRAME_BITS = 16;
	localparam int unsigned DATA_START = 8;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned ITEMS_PER_PHASE = 80;
	localparam logic [3:0] ADDR_INIT_TIME = {REG_INIT_TIME, 3'b000};
	localparam logic [3:0] ADDR_UNMAPPED = 4'd8;
	localparam logic [55:0] INIT_TIME_MAX = {INIT_TIME_W{1'b1}};

	// results that can be read off at a glance
	localparam pins_t PINS_RESET = '{sclk: 1'b0, io_out: 1'b1, io_drive: 1'b0, enable: 1'b0,
		busy: 1'b0, done: 1'b0, rd: 8'h00, halted: 1'b0, rejected: 1'b0};
	// write to register 63: command bit 0 is the read flag, low
	localparam pins_t PINS_WRITE_START = '{sclk: 1'b0, io_out: 1'b0, io_drive: 1'b1,
		enable: 1'b1, busy: 1'b1, done: 1'b0, rd: 8'h00, halted: 1'b0, rejected: 1'b0};
	localparam pins_t PINS_BUSY_REJECT = '{sclk: 1'b0, io_out: 1'b0, io_drive: 1'b1,
		enable: 1'b1, busy: 1'b1, done: 1'b0, rd: 8'h00, halted: 1'b0, rejected: 1'b1};

	localparam int unsigned NUM_ROWS = 19;
	localparam stim_row_t DIR_ROWS [0:NUM_ROWS-1] = '{
		'{CMD_TICK,  6'd0,  8'h00, 1'b0, 9'd1,   1'b1, PINS_RESET},
		'{CMD_WRITE, 6'd63, 8'hFF, 1'b1, 9'd1,   1'b1, PINS_WRITE_START},
		'{CMD_INIT,  6'd0,  8'h00, 1'b0, 9'd1,   1'b1, PINS_BUSY_REJECT},
		'{CMD_TICK,  6'd0,  8'h00, 1'b1, 9'd32,  1'b0, '0},
		'{CMD_WRITE, 6'd0,  8'h00, 1'b0, 9'd1,   1'b0, '0},
		'{CMD_TICK,  6'd63, 8'hFF, 1'b0, 9'd32,  1'b0, '0},
		'{CMD_READ,  6'd63, 8'hFF, 1'b0, 9'd1,   1'b0, '0},
		'{CMD_TICK,  6'd0,  8'h00, 1'b1, 9'd32,  1'b0, '0},
		'{CMD_READ,  6'd0,  8'h00, 1'b1, 9'd1,   1'b0, '0},
		'{CMD_TICK,  6'd0,  8'h00, 1'b0, 9'd20,  1'b0, '0},
		'{CMD_WRITE, 6'd5,  8'hAA, 1'b0, 9'd1,   1'b0, '0},
		'{CMD_TICK,  6'd0,  8'h00, 1'b0, 9'd12,  1'b0, '0},
		'{CMD_INIT,  6'd0,  8'h00, 1'b0, 9'd1,   1'b0, '0},
		'{CMD_TICK,  6'd0,  8'h00, 1'b1, 9'd100, 1'b0, '0},
		'{CMD_READ,  6'd21, 8'h00, 1'b0, 9'd1,   1'b0, '0},
		'{CMD_TICK,  6'd0,  8'h00, 1'b1, 9'd200, 1'b0, '0},
		'{CMD_INIT,  6'd0,  8'h00, 1'b0, 9'd1,   1'b0, '0},
		'{CMD_TICK,  6'd0,  8'h00, 1'b0, 9'd34,  1'b0, '0},
		'{CMD_TICK,  6'd0,  8'h00, 1'b0, 9'd1,   1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_TICK;
	logic [5:0]  reg_addr = '0;
	logic [7:0]  write_data = '0;
	logic        io_in = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        sclk;
	logic        io_out;
	logic        io_drive;
	logic        enable;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_data;
	logic        clock_was_halted;
	logic        rejected;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	rtc_three_wire_serial_master_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .reg_addr(reg_addr), .write_data(write_data), .io_in(io_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.sclk(sclk), .io_out(io_out), .io_drive(io_drive), .enable(enable),
		.busy_res(busy_res), .done_res(done_res), .read_data(read_data),
		.clock_was_halted(clock_was_halted), .rejected(rejected),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bus model state, mirrors the unit after reset
	mode_t       bus_mode = MODE_IDLE;
	logic [3:0]  init_step = STEP_READ_HALT;
	logic [4:0]  bit_pos = '0;
	logic        phase = 1'b0;
	logic [15:0] shreg = '0;
	logic [7:0]  rx_byte = '0;
	logic [7:0]  last_rx = '0;
	logic        halt_seen = 1'b0;
	logic [55:0] time_cfg = INIT_TIME_RESET;

	pins_t pending_pins [$];
	pins_t pinned_pins [int];
	int    items_sent = 0;
	int    items_taken = 0;
	int    results_seen = 0;
	int    fail_count = 0;
	int    cycle_count = 0;
	bit    idle_on = 1'b1;

	task automatic report_mismatch(input string what, input logic [63:0] got_v,
			input logic [63:0] want_v);
		$display("mismatch %s at result %0d: got %0h want %0h", what, results_seen,
			got_v, want_v);
		fail_count++;
	endtask

	function automatic bit reading_frame();
		return bus_mode == MODE_READ || (bus_mode == MODE_INIT && init_step == STEP_READ_HALT);
	endfunction

	// command byte is {1, reg, read flag}, data byte behind it
	function automatic void load_frame(input logic [5:0] r, input logic [7:0] d, input logic rd);
		shreg = {d, 1'b1, r, rd};
		rx_byte = '0;
		bit_pos = '0;
		phase = 1'b0;
	endfunction

	function automatic void load_step();
		int idx;
		if (init_step == STEP_READ_HALT) begin
			load_frame(DEV_REG_SECONDS, 8'h00, 1'b1);
		end else if (init_step == STEP_WRITE_WP) begin
			load_frame(DEV_REG_WP, 8'h00, 1'b0);
		end else begin
			idx = int'(init_step) - 2;
			if (idx > int'(LAST_TIME_IDX))
				idx = int'(LAST_TIME_IDX);
			load_frame(6'(idx), time_cfg[8*idx +: 8], 1'b0);
		end
	endfunction

	function automatic void go_idle();
		bus_mode = MODE_IDLE;
		init_step = STEP_READ_HALT;
		bit_pos = '0;
		phase = 1'b0;
	endfunction

	// advance the bus model by one item and return the pins after it
	function automatic pins_t bus_step(input logic [1:0] op, input logic [5:0] r,
			input logic [7:0] d, input logic b);
		pins_t p;
		p = '0;
		if (op != CMD_TICK) begin
			if (bus_mode != MODE_IDLE) begin
				p.rejected = 1'b1;
			end else if (op == CMD_WRITE) begin
				bus_mode = MODE_WRITE;
				load_frame(r, d, 1'b0);
			end else if (op == CMD_READ) begin
				bus_mode = MODE_READ;
				load_frame(r, 8'h00, 1'b1);
			end else begin
				bus_mode = MODE_INIT;
				init_step = STEP_READ_HALT;
				halt_seen = 1'b0;
				load_step();
			end
		end else if (bus_mode != MODE_IDLE) begin
			if (bit_pos >= FRAME_BITS) begin
				load_step();
			end else if (!phase) begin
				if (reading_frame() && bit_pos >= DATA_START)
					rx_byte[bit_pos[2:0]] = b;
				phase = 1'b1;
			end else begin
				phase = 1'b0;
				bit_pos++;
				if (bit_pos >= FRAME_BITS) begin
					if (reading_frame())
						last_rx = rx_byte;
					if (bus_mode != MODE_INIT) begin
						go_idle();
						p.done = 1'b1;
					end else if (init_step == STEP_READ_HALT) begin
						if (last_rx[HALT_BIT]) begin
							halt_seen = 1'b1;
							init_step = STEP_WRITE_WP;
						end else begin
							go_idle();
							p.done = 1'b1;
						end
					end else if (init_step < STEP_LAST) begin
						init_step++;
					end else begin
						go_idle();
						p.done = 1'b1;
					end
				end
			end
		end
		// pins: released high when idle, in a gap, or on read data bits
		if (bus_mode == MODE_IDLE || bit_pos >= FRAME_BITS) begin
			p.io_out = 1'b1;
		end else begin
			p.sclk = phase;
			p.enable = 1'b1;
			if (bit_pos < DATA_START || !reading_frame()) begin
				p.io_drive = 1'b1;
				p.io_out = shreg[bit_pos[3:0]];
			end else begin
				p.io_out = 1'b1;
			end
		end
		p.busy = (bus_mode != MODE_IDLE);
		p.rd = last_rx;
		p.halted = halt_seen;
		return p;
	endfunction

	// result checking and prediction, both on the pre-edge values
	always @(posedge clk) begin : monitor
		pins_t got;
		pins_t want;
		pins_t pred;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {sclk, io_out, io_drive, enable, busy_res, done_res, read_data,
					clock_was_halted, rejected};
				if (pending_pins.size() == 0) begin
					report_mismatch("unexpected result", 64'(got), '0);
				end else begin
					want = pending_pins.pop_front();
					if (got.sclk !== want.sclk)
						report_mismatch("sclk", 64'(got.sclk), 64'(want.sclk));
					if (got.io_out !== want.io_out)
						report_mismatch("io_out", 64'(got.io_out), 64'(want.io_out));
					if (got.io_drive !== want.io_drive)
						report_mismatch("io_drive", 64'(got.io_drive), 64'(want.io_drive));
					if (got.enable !== want.enable)
						report_mismatch("enable", 64'(got.enable), 64'(want.enable));
					if (got.busy !== want.busy)
						report_mismatch("busy_res", 64'(got.busy), 64'(want.busy));
					if (got.done !== want.done)
						report_mismatch("done_res", 64'(got.done), 64'(want.done));
					if (got.rd !== want.rd)
						report_mismatch("read_data", 64'(got.rd), 64'(want.rd));
					if (got.halted !== want.halted)
						report_mismatch("clock_was_halted", 64'(got.halted),
							64'(want.halted));
					if (got.rejected !== want.rejected)
						report_mismatch("rejected", 64'(got.rejected), 64'(want.rejected));
				end
				results_seen++;
			end
			if (in_valid && in_ready) begin
				pred = bus_step(cmd, reg_addr, write_data, io_in);
				if (pinned_pins.exists(items_taken))
					pred = pinned_pins[items_taken];
				pending_pins.push_back(pred);
				items_taken++;
			end
		end
	end

	// result side stalls
	always @(posedge clk) begin
		if (idle_on)
			out_ready <= ($urandom_range(0, 99) >= 10);
		else
			out_ready <= 1'b1;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// one input transfer, with optional random gaps before it
	task automatic drive_item(input logic [1:0] c, input logic [5:0] r, input logic [7:0] d,
			input logic b);
		while (idle_on && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		reg_addr <= r;
		write_data <= d;
		io_in <= b;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	// hold off the sender until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pins.size() != 0)
			@(posedge clk);
	endtask

	// tick until the bus is idle and all results are back
	task automatic finish_phase();
		do begin
			while (bus_mode != MODE_IDLE)
				drive_item(CMD_TICK, 6'($urandom), 8'($urandom), 1'($urandom));
			drain();
		end while (bus_mode != MODE_IDLE);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [3:0] a, input logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (a == ADDR_INIT_TIME)
			time_cfg = v[55:0];
	endtask

	task automatic apb_check(input logic [55:0] want_v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_INIT_TIME;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[55:0] !== want_v)
			report_mismatch("init_time readback", 64'(prdata[55:0]), 64'(want_v));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		logic [55:0] cfg_val;
		logic [1:0]  op;
		bit          busy_now;
		int          made;
		int          ph;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset init_time
		apb_check(INIT_TIME_RESET);
		foreach (DIR_ROWS[i]) begin
			for (int k = 0; k < int'(DIR_ROWS[i].reps); k++) begin
				if (k == 0 && DIR_ROWS[i].has_want)
					pinned_pins[items_sent] = DIR_ROWS[i].want;
				drive_item(DIR_ROWS[i].op, DIR_ROWS[i].addr, DIR_ROWS[i].data, DIR_ROWS[i].pin);
			end
		end
		finish_phase();

		// a write outside the register map leaves init_time alone
		apb_write(ADDR_UNMAPPED, {$urandom, $urandom});
		apb_check(time_cfg);

		// five phases, each with its own init_time: all zeros, all ones, then random
		for (ph = 0; ph < 5; ph++) begin
			if (ph == 0)
				cfg_val = '0;
			else if (ph == 1)
				cfg_val = INIT_TIME_MAX;
			else
				cfg_val = 56'({$urandom, $urandom});
			apb_write(ADDR_INIT_TIME, {8'h00, cfg_val});
			apb_check(cfg_val);
			// no stalls on either side for one whole phase
			idle_on = (ph != 2);
			made = 0;
			while (made < ITEMS_PER_PHASE) begin
				busy_now = (bus_mode != MODE_IDLE);
				if (busy_now)
					op = ($urandom_range(0, 99) < 4) ? 2'($urandom_range(1, 3)) : CMD_TICK;
				else
					op = ($urandom_range(0, 99) < 75) ? 2'($urandom_range(1, 3)) : CMD_TICK;
				drive_item(op, 6'($urandom), 8'($urandom), 1'($urandom));
				if (busy_now ? (op == CMD_TICK) : (op != CMD_TICK))
					made++;
			end
			finish_phase();
			idle_on = 1'b1;
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/rtc3w_pkg.sv
rtl/rtc_three_wire_serial_master_unit.sv
verif/testbench.sv
